// ----- hw/rtl/dlsq_pkg.sv -----
`default_nettype none
package dlsq_pkg;

    localparam int LIST_CAPACITY_DEFAULT = 16;
    localparam int MAX_RESULTS = 32;

    localparam int ID_W = 8;
    localparam int TICK_W = 16;
    localparam int COUNT_W = 6;
    localparam int CMD_W = 2;
    localparam int CAUSE_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam logic [CAUSE_W-1:0] CAUSE_SIGNAL = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] delta;
    } timed_entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dlsq_req_if.sv -----
`default_nettype none
interface dlsq_req_if
    import dlsq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [ID_W-1:0]    thread_id;
    logic [TICK_W-1:0]  wait_ticks;
    logic [COUNT_W-1:0] release_count;

    modport source (output valid, cmd, thread_id, wait_ticks, release_count, input ready);
    modport sink (input valid, cmd, thread_id, wait_ticks, release_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dlsq_rsp_if.sv -----
`default_nettype none
interface dlsq_rsp_if
    import dlsq_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ID_W-1:0]    woken_id;
    logic [CAUSE_W-1:0] cause;
    logic               last;

    modport source (output valid, woken_id, cause, last, input ready);
    modport sink (input valid, woken_id, cause, last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/dlsq_ram.sv -----
`default_nettype none
module dlsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/delta_list_sleep_queue_top.sv -----
// channel | dir | transfer carries
// req     | in  | cmd, thread_id, wait_ticks, release_count
// rsp     | out | woken_id, cause, last
// One command at a time; req.ready is high only while the sequencer is idle.
// Add to FIFO or to an empty list: done in idle. Timed add: S_SCAN walks the list
// RAM, then appends at the tail, or S_SHIFT moves entries up and S_INS inserts.
// Release: S_REL_F per FIFO waiter, S_REL_T per timed (+S_CARRY). Tick: S_TK_*.
// rsp stalls hold the sequencer in its emit state; rsp is a registered stage.
// rst_n clears the state, counts, pointers and flags only; the RAMs need no clearing.
`default_nettype none
module delta_list_sleep_queue_top
    import dlsq_pkg::*;
#(
    parameter int LIST_CAPACITY = LIST_CAPACITY_DEFAULT
) (
    input wire logic  clk,
    input wire logic  rst_n,
    dlsq_req_if.sink  req,
    dlsq_rsp_if.source rsp
);

    localparam int AW = $clog2(LIST_CAPACITY);
    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int PW = CW + 1;
    localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);
    localparam logic [COUNT_W-1:0] MAXR = COUNT_W'(MAX_RESULTS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_REJ     = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_SHIFT   = 4'd3;
    localparam logic [3:0] S_INS     = 4'd4;
    localparam logic [3:0] S_REL     = 4'd5;
    localparam logic [3:0] S_REL_F   = 4'd6;
    localparam logic [3:0] S_REL_T   = 4'd7;
    localparam logic [3:0] S_CARRY   = 4'd8;
    localparam logic [3:0] S_TK_CHK  = 4'd9;
    localparam logic [3:0] S_TK_EMIT = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      tcnt_reg, tcnt_next;
    logic [AW-1:0]      thead_reg, thead_next;
    logic [CW-1:0]      fcnt_reg, fcnt_next;
    logic [AW-1:0]      fhead_reg, fhead_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic               first_reg, first_next;
    logic               lastf_reg, lastf_next;
    logic [AW-1:0]      k_reg, k_next;
    logic [AW-1:0]      j_reg, j_next;
    logic [TICK_W-1:0]  rem_reg, rem_next;
    logic [TICK_W-1:0]  carried_reg, carried_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [ID_W-1:0]    pend_reg, pend_next;

    logic               ov_reg, ov_next;
    logic [ID_W-1:0]    oid_reg, oid_next;
    logic [CAUSE_W-1:0] ocause_reg, ocause_next;
    logic               olast_reg, olast_next;

    logic               t_we;
    logic [AW-1:0]      t_waddr, t_raddr;
    timed_entry_t       t_wdata, t_rdata;
    logic [CW-1:0]      rd_l;
    logic               f_we;
    logic [AW-1:0]      f_waddr;
    logic [ID_W-1:0]    f_wdata, f_rdata;

    logic               can_emit;
    logic               accept;
    logic [TICK_W-1:0]  d_dec;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [PW-1:0] s;
        begin
            s = PW'(base) + PW'(off);
            if (s >= PW'(LIST_CAPACITY))
            begin
                s = s - PW'(LIST_CAPACITY);
            end
            return s[AW-1:0];
        end
    endfunction

    dlsq_ram #(.WIDTH($bits(timed_entry_t)), .DEPTH(LIST_CAPACITY)) u_timed_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (t_wdata),
        .raddr (t_raddr),
        .rdata (t_rdata)
    );

    dlsq_ram #(.WIDTH(ID_W), .DEPTH(LIST_CAPACITY)) u_fifo_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .raddr (fhead_reg),
        .rdata (f_rdata)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept = req.valid && req.ready;
    assign can_emit = !ov_reg || rsp.ready;
    assign rsp.valid = ov_reg;
    assign rsp.woken_id = oid_reg;
    assign rsp.cause = ocause_reg;
    assign rsp.last = olast_reg;
    assign t_raddr = wrap_add(thead_reg, rd_l);
    assign d_dec = (t_rdata.delta != '0) ? t_rdata.delta - 1'b1 : t_rdata.delta;

    always_comb
    begin
        state_next = state_reg;
        tcnt_next = tcnt_reg;
        thead_next = thead_reg;
        fcnt_next = fcnt_reg;
        fhead_next = fhead_reg;
        cnt_next = cnt_reg;
        n_next = n_reg;
        first_next = first_reg;
        lastf_next = lastf_reg;
        k_next = k_reg;
        j_next = j_reg;
        rem_next = rem_reg;
        carried_next = carried_reg;
        id_next = id_reg;
        pend_next = pend_reg;
        ov_next = ov_reg && !rsp.ready;
        oid_next = oid_reg;
        ocause_next = ocause_reg;
        olast_next = olast_reg;
        t_we = 1'b0;
        t_waddr = thead_reg;
        t_wdata = t_rdata;
        rd_l = '0;
        f_we = 1'b0;
        f_waddr = wrap_add(fhead_reg, fcnt_reg);
        f_wdata = req.thread_id;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    id_next = req.thread_id;
                    case (req.cmd)
                        CMD_ADD:
                        begin
                            if (req.wait_ticks == '0)
                            begin
                                if (fcnt_reg == CAP)
                                begin
                                    state_next = S_REJ;
                                end
                                else
                                begin
                                    f_we = 1'b1;
                                    fcnt_next = fcnt_reg + 1'b1;
                                end
                            end
                            else if (tcnt_reg == CAP)
                            begin
                                state_next = S_REJ;
                            end
                            else if (tcnt_reg == '0)
                            begin
                                t_we = 1'b1;
                                t_wdata = '{id: req.thread_id, delta: req.wait_ticks};
                                tcnt_next = tcnt_reg + 1'b1;
                            end
                            else
                            begin
                                k_next = '0;
                                rem_next = req.wait_ticks;
                                state_next = S_SCAN;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            cnt_next = (req.release_count > MAXR) ? MAXR : req.release_count;
                            state_next = S_REL;
                        end
                        CMD_TICK:
                        begin
                            if (tcnt_reg != '0)
                            begin
                                first_next = 1'b1;
                                n_next = '0;
                                state_next = S_TK_CHK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REJ:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    oid_next = id_reg;
                    ocause_next = CAUSE_FULL;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (rem_reg >= t_rdata.delta)
                begin
                    rem_next = rem_reg - t_rdata.delta;
                    if (CW'(k_reg) + 1'b1 == tcnt_reg)
                    begin
                        // goes after every entry: append at the tail
                        t_we = 1'b1;
                        t_waddr = wrap_add(thead_reg, tcnt_reg);
                        t_wdata = '{id: id_reg, delta: rem_reg - t_rdata.delta};
                        tcnt_next = tcnt_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        rd_l = CW'(k_reg) + 1'b1;
                    end
                end
                else
                begin
                    j_next = AW'(tcnt_reg - 1'b1);
                    rd_l = tcnt_reg - 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move entry j up one slot; the successor of the new entry loses rem
                t_we = 1'b1;
                t_waddr = wrap_add(thead_reg, CW'(j_reg) + 1'b1);
                t_wdata.id = t_rdata.id;
                t_wdata.delta = (j_reg == k_reg) ? t_rdata.delta - rem_reg : t_rdata.delta;
                if (j_reg == k_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                    rd_l = CW'(j_reg) - 1'b1;
                end
            end
            S_INS:
            begin
                t_we = 1'b1;
                t_waddr = wrap_add(thead_reg, CW'(k_reg));
                t_wdata = '{id: id_reg, delta: rem_reg};
                tcnt_next = tcnt_reg + 1'b1;
                state_next = S_IDLE;
            end
            S_REL:
            begin
                if (cnt_reg == '0 || (fcnt_reg == '0 && tcnt_reg == '0))
                begin
                    state_next = S_IDLE;
                end
                else if (fcnt_reg != '0)
                begin
                    state_next = S_REL_F;
                end
                else
                begin
                    state_next = S_REL_T;
                end
            end
            S_REL_F:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    oid_next = f_rdata;
                    ocause_next = CAUSE_SIGNAL;
                    olast_next = (cnt_reg == 1) || (fcnt_reg == 1 && tcnt_reg == '0);
                    fhead_next = wrap_add(fhead_reg, CW'(1));
                    fcnt_next = fcnt_reg - 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_REL;
                end
            end
            S_REL_T:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    oid_next = t_rdata.id;
                    ocause_next = CAUSE_SIGNAL;
                    olast_next = (cnt_reg == 1) || (tcnt_reg == 1);
                    carried_next = t_rdata.delta;
                    thead_next = wrap_add(thead_reg, CW'(1));
                    tcnt_next = tcnt_reg - 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                    if (tcnt_reg > 1)
                    begin
                        rd_l = CW'(1);
                        state_next = S_CARRY;
                    end
                    else
                    begin
                        state_next = S_REL;
                    end
                end
            end
            S_CARRY:
            begin
                t_we = 1'b1;
                t_wdata.id = t_rdata.id;
                t_wdata.delta = t_rdata.delta + carried_reg;
                state_next = S_REL;
            end
            S_TK_CHK:
            begin
                if (first_reg)
                begin
                    if (d_dec != '0)
                    begin
                        t_we = 1'b1;
                        t_wdata.id = t_rdata.id;
                        t_wdata.delta = d_dec;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pend_next = t_rdata.id;
                        thead_next = wrap_add(thead_reg, CW'(1));
                        tcnt_next = tcnt_reg - 1'b1;
                        n_next = COUNT_W'(1);
                        first_next = 1'b0;
                        if (tcnt_reg == 1)
                        begin
                            lastf_next = 1'b1;
                            state_next = S_TK_EMIT;
                        end
                        else
                        begin
                            rd_l = CW'(1);
                        end
                    end
                end
                else
                begin
                    lastf_next = !(t_rdata.delta == '0 && n_reg < MAXR);
                    state_next = S_TK_EMIT;
                end
            end
            S_TK_EMIT:
            begin
                if (can_emit)
                begin
                    ov_next = 1'b1;
                    oid_next = pend_reg;
                    ocause_next = CAUSE_TIMEOUT;
                    olast_next = lastf_reg;
                    if (lastf_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // head already read and known to be due
                        pend_next = t_rdata.id;
                        thead_next = wrap_add(thead_reg, CW'(1));
                        tcnt_next = tcnt_reg - 1'b1;
                        n_next = n_reg + 1'b1;
                        if (tcnt_reg == 1)
                        begin
                            lastf_next = 1'b1;
                        end
                        else
                        begin
                            rd_l = CW'(1);
                            state_next = S_TK_CHK;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tcnt_reg <= '0;
            thead_reg <= '0;
            fcnt_reg <= '0;
            fhead_reg <= '0;
            cnt_reg <= '0;
            n_reg <= '0;
            first_reg <= 1'b0;
            lastf_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tcnt_reg <= tcnt_next;
            thead_reg <= thead_next;
            fcnt_reg <= fcnt_next;
            fhead_reg <= fhead_next;
            cnt_reg <= cnt_next;
            n_reg <= n_next;
            first_reg <= first_next;
            lastf_reg <= lastf_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        j_reg <= j_next;
        rem_reg <= rem_next;
        carried_reg <= carried_next;
        id_reg <= id_next;
        pend_reg <= pend_next;
        oid_reg <= oid_next;
        ocause_reg <= ocause_next;
        olast_reg <= olast_next;
    end

endmodule
`default_nettype wire
